>>> hw/rtl/nlej_pkg.sv
// ----------------------------------------------------------------------------
// nlej_pkg
// Shared types and codes for the nested loop equi-join block.
// ----------------------------------------------------------------------------
package nlej_pkg;

   localparam int LEFT_DEPTH_DEF = 64;
   localparam int FIELD_W        = 32;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_PROBE = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [2:0] ST_LOADED   = 3'd0;
   localparam logic [2:0] ST_MATCH    = 3'd1;
   localparam logic [2:0] ST_NO_MATCH = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_CLEARED  = 3'd4;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_FINISH
   } fsm_type;

   typedef enum logic [2:0] {
      EMIT_NONE,
      EMIT_LOADED,
      EMIT_FULL,
      EMIT_CLEARED,
      EMIT_PAIR,
      EMIT_NO_MATCH
   } emit_type;

   typedef struct packed {
      emit_type emit;
      logic     emit_last;
      logic     load_wr;
      logic     clear;
      logic     probe_start;
      logic     scan_adv;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic table_full;
      logic cmp_vld;
      logic cmp_match;
      logic pend_vld;
      logic fetch_done;
   } stat_type;

endpackage

>>> hw/rtl/nlej_intf.sv
// ----------------------------------------------------------------------------
// nlej_req_intf / nlej_rsp_intf
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface nlej_req_intf;
   logic               valid;
   logic               ready;
   logic [1:0]         op;
   logic signed [31:0] tuple_key;
   logic signed [31:0] tuple_value;

   modport source (output valid, output op, output tuple_key, output tuple_value,
                   input ready);
   modport sink   (input valid, input op, input tuple_key, input tuple_value,
                   output ready);
endinterface

interface nlej_rsp_intf;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic signed [31:0] left_key;
   logic signed [31:0] left_value;
   logic signed [31:0] right_key;
   logic signed [31:0] right_value;
   logic               last;

   modport source (output valid, output status, output left_key, output left_value,
                   output right_key, output right_value, output last,
                   input ready);
   modport sink   (input valid, input status, input left_key, input left_value,
                   input right_key, input right_value, input last,
                   output ready);
endinterface

>>> hw/rtl/nested_loop_equi_join_top.sv
// ----------------------------------------------------------------------------
// nested_loop_equi_join_top
// Equi-join engine on the value field over an on-chip left table.
// ----------------------------------------------------------------------------
// Load, clear and unused-op items return one result each (none for the
// unused op), and the next item is taken once the result register is free.
// A probe reads the left table through its single registered read port,
// one stored tuple per cycle while the result side does not stall a match,
// and no new item is taken until its final result has been registered.
// Matches leave in table order; the last result of each item carries last.
// ----------------------------------------------------------------------------
module nested_loop_equi_join_top #(
   parameter int LEFT_DEPTH = nlej_pkg::LEFT_DEPTH_DEF
) (
   input logic          clock,
   input logic          reset,
   nlej_req_intf.sink   req_chan,
   nlej_rsp_intf.source rsp_chan
);
   import nlej_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   nlej_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.op),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   nlej_datapath #(
      .LEFT_DEPTH (LEFT_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_tuple_key   (req_chan.tuple_key),
      .req_tuple_value (req_chan.tuple_value),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_status      (rsp_chan.status),
      .rsp_left_key    (rsp_chan.left_key),
      .rsp_left_value  (rsp_chan.left_value),
      .rsp_right_key   (rsp_chan.right_key),
      .rsp_right_value (rsp_chan.right_value),
      .rsp_last        (rsp_chan.last)
   );

endmodule

>>> hw/rtl/nlej_ctrl.sv
// ----------------------------------------------------------------------------
// nlej_ctrl
// Sequencer: decodes request items and steps the probe scan.
// ----------------------------------------------------------------------------
module nlej_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [1:0]        req_op,
   output logic              req_ready,
   input  nlej_pkg::stat_type stat,
   output nlej_pkg::cmd_type  cmd
);
   import nlej_pkg::*;

   fsm_type state_ff;
   fsm_type state_in;
   logic    stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.emit  = EMIT_NONE;
      req_ready = 1'b0;
      stall     = 1'b0;
      unique case (state_ff)
         FSM_IDLE: begin
            req_ready = stat.out_free;
            if (req_valid && stat.out_free) begin
               unique case (req_op)
                  OP_LOAD: begin
                     cmd.emit      = stat.table_full ? EMIT_FULL : EMIT_LOADED;
                     cmd.emit_last = 1'b1;
                     cmd.load_wr   = !stat.table_full;
                  end
                  OP_PROBE: begin
                     cmd.probe_start = 1'b1;
                     state_in        = FSM_SCAN;
                  end
                  OP_CLEAR: begin
                     cmd.emit      = EMIT_CLEARED;
                     cmd.emit_last = 1'b1;
                     cmd.clear     = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         FSM_SCAN: begin
            if (!stat.cmp_vld && stat.fetch_done) begin
               state_in = FSM_FINISH;
            end else begin
               stall = stat.cmp_vld && stat.cmp_match && stat.pend_vld && !stat.out_free;
               cmd.scan_adv = !stall;
               if (!stall && stat.cmp_vld && stat.cmp_match && stat.pend_vld) begin
                  cmd.emit = EMIT_PAIR;
               end
            end
         end
         FSM_FINISH: begin
            if (stat.out_free) begin
               cmd.emit      = stat.pend_vld ? EMIT_PAIR : EMIT_NO_MATCH;
               cmd.emit_last = 1'b1;
               state_in      = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

endmodule

>>> hw/rtl/nlej_datapath.sv
// ----------------------------------------------------------------------------
// nlej_datapath
// Left table memory, scan pipeline, pending match and result register.
// ----------------------------------------------------------------------------
module nlej_datapath #(
   parameter int LEFT_DEPTH = nlej_pkg::LEFT_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  nlej_pkg::cmd_type  cmd,
   output nlej_pkg::stat_type stat,
   input  logic signed [31:0] req_tuple_key,
   input  logic signed [31:0] req_tuple_value,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_left_key,
   output logic signed [31:0] rsp_left_value,
   output logic signed [31:0] rsp_right_key,
   output logic signed [31:0] rsp_right_value,
   output logic               rsp_last
);
   import nlej_pkg::*;

   localparam int CNT_W = $clog2(LEFT_DEPTH + 1);
   localparam int AW    = (LEFT_DEPTH > 1) ? $clog2(LEFT_DEPTH) : 1;

   logic [2*FIELD_W-1:0] mem [LEFT_DEPTH];
   logic [2*FIELD_W-1:0] rd_q_ff;

   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   idx_ff;
   logic               cmp_vld_ff;
   logic               pend_vld_ff;
   logic signed [31:0] pend_key_ff;
   logic signed [31:0] pend_val_ff;
   logic signed [31:0] right_key_ff;
   logic signed [31:0] right_val_ff;
   logic               out_vld_ff;
   logic               cmp_match;

   assign cmp_match = (rd_q_ff[FIELD_W-1:0] == right_val_ff);

   assign stat.out_free   = !out_vld_ff || rsp_ready;
   assign stat.table_full = (count_ff == CNT_W'(LEFT_DEPTH));
   assign stat.cmp_vld    = cmp_vld_ff;
   assign stat.cmp_match  = cmp_match;
   assign stat.pend_vld   = pend_vld_ff;
   assign stat.fetch_done = (idx_ff >= count_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_wr) begin
         mem[count_ff[AW-1:0]] <= {req_tuple_key, req_tuple_value};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_adv) begin
         rd_q_ff <= mem[idx_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         idx_ff      <= '0;
         cmp_vld_ff  <= 1'b0;
         pend_vld_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            count_ff <= '0;
         end else if (cmd.load_wr) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.probe_start) begin
            idx_ff      <= '0;
            cmp_vld_ff  <= 1'b0;
            pend_vld_ff <= 1'b0;
         end else if (cmd.scan_adv) begin
            if (idx_ff < count_ff) begin
               cmp_vld_ff <= 1'b1;
               idx_ff     <= idx_ff + CNT_W'(1);
            end else begin
               cmp_vld_ff <= 1'b0;
            end
            if (cmp_vld_ff && cmp_match) begin
               pend_vld_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.probe_start) begin
         right_key_ff <= req_tuple_key;
         right_val_ff <= req_tuple_value;
      end
      if (cmd.scan_adv && cmp_vld_ff && cmp_match) begin
         pend_key_ff <= rd_q_ff[2*FIELD_W-1:FIELD_W];
         pend_val_ff <= rd_q_ff[FIELD_W-1:0];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (cmd.emit != EMIT_NONE) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit != EMIT_NONE) begin
         rsp_left_key    <= '0;
         rsp_left_value  <= '0;
         rsp_right_key   <= '0;
         rsp_right_value <= '0;
         rsp_last        <= cmd.emit_last;
         case (cmd.emit)
            EMIT_LOADED:  rsp_status <= ST_LOADED;
            EMIT_FULL:    rsp_status <= ST_FULL;
            EMIT_CLEARED: rsp_status <= ST_CLEARED;
            EMIT_PAIR: begin
               rsp_status      <= ST_MATCH;
               rsp_left_key    <= pend_key_ff;
               rsp_left_value  <= pend_val_ff;
               rsp_right_key   <= right_key_ff;
               rsp_right_value <= right_val_ff;
            end
            default: begin
               rsp_status      <= ST_NO_MATCH;
               rsp_right_key   <= right_key_ff;
               rsp_right_value <= right_val_ff;
            end
         endcase
      end
   end

   assign rsp_valid = out_vld_ff;

endmodule

>>> hw/rtl/nlej_checker.sv
// ----------------------------------------------------------------------------
// nlej_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module nlej_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [2:0]         rsp_status,
   input logic signed [31:0] rsp_left_key,
   input logic signed [31:0] rsp_left_value,
   input logic signed [31:0] rsp_right_key,
   input logic signed [31:0] rsp_right_value,
   input logic               rsp_last
);
   import nlej_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_left_key) && $stable(rsp_right_value) && $stable(rsp_last))
      else $error("stalled result changed");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_CLEARED)
      else $error("bad status code");

   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_MATCH |-> rsp_last)
      else $error("single result without last");

   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_LOADED || rsp_status == ST_FULL
         || rsp_status == ST_CLEARED)
      |-> rsp_left_key == 0 && rsp_left_value == 0 && rsp_right_key == 0
         && rsp_right_value == 0)
      else $error("table result with nonzero tuple fields");

   a_nomatch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_NO_MATCH |-> rsp_left_key == 0 && rsp_left_value == 0)
      else $error("no-match result with left tuple");

endmodule

bind nested_loop_equi_join_top nlej_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_left_key    (rsp_chan.left_key),
   .rsp_left_value  (rsp_chan.left_value),
   .rsp_right_key   (rsp_chan.right_key),
   .rsp_right_value (rsp_chan.right_value),
   .rsp_last        (rsp_chan.last)
);

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for nested_loop_equi_join_top. A queue-fed driver
// offers load, probe, clear and unused-op items on the request channel. A
// predictor keeps its own copy of the left table and works out every result
// of each accepted item. A monitor compares each result with the oldest one
// still expected. Both sides idle at random, and once the result side holds
// off for a long stretch so that the block backs up into its request channel.
// ----------------------------------------------------------------------------
module tb;
   import nlej_pkg::*;

   localparam int         LEFT_DEPTH   = LEFT_DEPTH_DEF;
   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam int         ITEM_TARGET  = 400;
   localparam int         CYCLE_LIMIT  = 1_500_000;
   localparam int         DRAIN_CYCLES = 200;
   localparam int         LONG_STALL   = 600;
   localparam int         STALL_AFTER  = 150;
   localparam int         MAX_PRINTS   = 30;

   typedef struct {
      logic [1:0]         op;
      logic signed [31:0] key;
      logic signed [31:0] value;
      int                 gap;
   } join_req_t;

   typedef struct {
      logic [2:0]         status;
      logic signed [31:0] left_key;
      logic signed [31:0] left_value;
      logic signed [31:0] right_key;
      logic signed [31:0] right_value;
      logic               last;
   } join_rsp_t;

   logic clock;
   logic reset;

   nlej_req_intf req_if ();
   nlej_rsp_intf rsp_if ();

   nested_loop_equi_join_top #(.LEFT_DEPTH(LEFT_DEPTH)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   join_req_t pending_reqs[$];
   join_rsp_t join_expect[$];
   join_req_t on_bus;

   logic signed [31:0] tbl_key [0:LEFT_DEPTH-1];
   logic signed [31:0] tbl_val [0:LEFT_DEPTH-1];
   int tbl_count = 0;

   int gen_count    = 0;
   int total_items  = 0;
   int items_taken  = 0;
   int results_seen = 0;
   int err_count    = 0;
   int cycle_count  = 0;
   int gap_left     = 0;
   int hold_left    = 0;
   int long_left    = 0;
   bit stall_done   = 0;

   int n_loads = 0, n_full = 0, n_probes = 0, n_pairs = 0, n_nomatch = 0, n_clears = 0;

   logic signed [31:0] value_pool [0:7];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[nested_loop_equi_join_top] ERROR");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      err_count++;
      if (err_count <= MAX_PRINTS)
         $display("cycle %0d mismatch: %s", cycle_count, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h want %h", name, got, want));
   endtask

   function automatic join_rsp_t make_rsp(input logic [2:0] status,
                                          input logic signed [31:0] lk,
                                          input logic signed [31:0] lv,
                                          input logic signed [31:0] rk,
                                          input logic signed [31:0] rv,
                                          input logic last);
      join_rsp_t r;
      r.status      = status;
      r.left_key    = lk;
      r.left_value  = lv;
      r.right_key   = rk;
      r.right_value = rv;
      r.last        = last;
      return r;
   endfunction

   function automatic void predict_join(input join_req_t it);
      int hits;
      int seen;
      hits = 0;
      seen = 0;
      case (it.op)
         OP_LOAD: begin
            if (tbl_count < LEFT_DEPTH) begin
               tbl_key[tbl_count] = it.key;
               tbl_val[tbl_count] = it.value;
               tbl_count++;
               n_loads++;
               join_expect.push_back(make_rsp(ST_LOADED, 0, 0, 0, 0, 1'b1));
            end else begin
               n_full++;
               join_expect.push_back(make_rsp(ST_FULL, 0, 0, 0, 0, 1'b1));
            end
         end
         OP_CLEAR: begin
            tbl_count = 0;
            n_clears++;
            join_expect.push_back(make_rsp(ST_CLEARED, 0, 0, 0, 0, 1'b1));
         end
         OP_PROBE: begin
            n_probes++;
            for (int i = 0; i < tbl_count; i++)
               if (tbl_val[i] == it.value) hits++;
            if (hits == 0) begin
               n_nomatch++;
               join_expect.push_back(make_rsp(ST_NO_MATCH, 0, 0, it.key, it.value, 1'b1));
            end else begin
               for (int i = 0; i < tbl_count; i++) begin
                  if (tbl_val[i] == it.value) begin
                     seen++;
                     n_pairs++;
                     join_expect.push_back(make_rsp(ST_MATCH, tbl_key[i], tbl_val[i],
                                                    it.key, it.value, seen == hits));
                  end
               end
            end
         end
         default: ;
      endcase
   endfunction

   // driver
   always @(posedge clock) begin : drv
      bit offering;
      if (reset) begin
         req_if.valid <= 1'b0;
         gap_left = 0;
      end else begin
         offering = req_if.valid;
         if (req_if.valid && req_if.ready) begin
            predict_join(on_bus);
            items_taken <= items_taken + 1;
            offering = 1'b0;
         end
         if (!offering) begin
            if (pending_reqs.size() == 0) begin
               req_if.valid <= 1'b0;
            end else if (gap_left < pending_reqs[0].gap) begin
               gap_left++;
               req_if.valid <= 1'b0;
            end else begin
               on_bus = pending_reqs.pop_front();
               gap_left = 0;
               req_if.op          <= on_bus.op;
               req_if.tuple_key   <= on_bus.key;
               req_if.tuple_value <= on_bus.value;
               req_if.valid       <= 1'b1;
            end
         end
      end
   end

   // long result-side hold-off, once, after the run is under way
   always @(posedge clock) begin
      if (reset) begin
         long_left  <= 0;
         stall_done <= 1'b0;
      end else if (!stall_done && items_taken >= STALL_AFTER) begin
         long_left  <= LONG_STALL;
         stall_done <= 1'b1;
      end else if (long_left > 0) begin
         long_left <= long_left - 1;
      end
   end

   // monitor
   always @(posedge clock) begin : mon
      join_rsp_t want;
      bit quiet;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (join_expect.size() == 0) begin
               report_mismatch($sformatf("unexpected result status %0d", rsp_if.status));
            end else begin
               want = join_expect.pop_front();
               check_field("status", 32'(rsp_if.status), 32'(want.status));
               check_field("left_key", rsp_if.left_key, want.left_key);
               check_field("left_value", rsp_if.left_value, want.left_value);
               check_field("right_key", rsp_if.right_key, want.right_key);
               check_field("right_value", rsp_if.right_value, want.right_value);
               check_field("last", 32'(rsp_if.last), 32'(want.last));
            end
            results_seen++;
            quiet = ((results_seen / 50) % 4) == 3;
            hold_left = quiet ? 0 : $urandom_range(0, 10);
         end else if (hold_left > 0) begin
            hold_left--;
         end
         rsp_if.ready <= (hold_left == 0) && (long_left == 0);
      end
   end

   task automatic add_item(input logic [1:0] op, input logic signed [31:0] key,
                           input logic signed [31:0] value, input bit quiet);
      join_req_t it;
      it.op    = op;
      it.key   = key;
      it.value = value;
      it.gap   = quiet ? 0 : $urandom_range(0, 10);
      pending_reqs.push_back(it);
      if (op != OP_UNUSED) gen_count++;
   endtask

   function automatic logic signed [31:0] pick_value();
      if ($urandom_range(0, 3) != 0) return value_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   initial begin : stim
      bit quiet;
      int kind;
      int n_ld;
      int n_pr;

      req_if.valid       = 1'b0;
      req_if.op          = OP_LOAD;
      req_if.tuple_key   = '0;
      req_if.tuple_value = '0;
      rsp_if.ready       = 1'b0;
      reset              = 1'b1;

      value_pool[0] = 32'sh0000_0000;
      value_pool[1] = 32'shFFFF_FFFF;
      value_pool[2] = 32'sh7FFF_FFFF;
      value_pool[3] = 32'sh8000_0000;
      value_pool[4] = 32'sh0000_0001;
      value_pool[5] = 32'sh0000_0005;
      value_pool[6] = 32'sh5555_5555;
      value_pool[7] = 32'shAAAA_AAAA;

      // directed: empty table, extremes, duplicates, no match, unused op, clear
      add_item(OP_PROBE, 32'sh0000_0007, 32'sh0000_0005, 0);
      add_item(OP_LOAD,  32'sh8000_0000, 32'sh7FFF_FFFF, 0);
      add_item(OP_LOAD,  32'sh7FFF_FFFF, 32'sh8000_0000, 0);
      add_item(OP_LOAD,  32'sh0000_0000, 32'sh0000_0000, 0);
      add_item(OP_LOAD,  32'shFFFF_FFFF, 32'sh7FFF_FFFF, 0);
      add_item(OP_PROBE, 32'sh1234_5678, 32'sh7FFF_FFFF, 0);
      add_item(OP_PROBE, 32'sh8000_0000, 32'sh8000_0000, 0);
      add_item(OP_PROBE, 32'sh7FFF_FFFF, 32'sh0000_3039, 0);
      add_item(OP_UNUSED, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 0);
      add_item(OP_PROBE, 32'shFFFF_FFFF, 32'sh0000_0000, 1);
      add_item(OP_LOAD,  32'sh5555_5555, 32'shFFFF_FFFF, 1);
      add_item(OP_PROBE, 32'shAAAA_AAAA, 32'shFFFF_FFFF, 1);
      add_item(OP_CLEAR, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 0);
      add_item(OP_PROBE, 32'sh0000_0001, 32'sh7FFF_FFFF, 0);
      add_item(OP_LOAD,  32'sh0000_0002, 32'sh7FFF_FFFF, 0);
      add_item(OP_PROBE, 32'sh0000_0003, 32'sh7FFF_FFFF, 0);
      add_item(OP_CLEAR, 32'sh0000_0000, 32'sh0000_0000, 0);

      // random: mostly load runs followed by probes, some noise
      while (gen_count < ITEM_TARGET) begin
         quiet = $urandom_range(0, 3) == 0;
         kind  = $urandom_range(0, 9);
         if (kind == 0) begin
            repeat ($urandom_range(1, 4))
               add_item(2'($urandom_range(0, 3)), $urandom, pick_value(), quiet);
         end else begin
            if ($urandom_range(0, 2) == 0) add_item(OP_CLEAR, $urandom, $urandom, quiet);
            n_ld = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 12);
            n_pr = $urandom_range(1, 5);
            repeat (n_ld) add_item(OP_LOAD, $urandom, pick_value(), quiet);
            repeat (n_pr) add_item(OP_PROBE, $urandom, pick_value(), quiet);
         end
      end
      total_items = pending_reqs.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (items_taken < total_items) @(posedge clock);
      while (join_expect.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (join_expect.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", join_expect.size()));

      $display("run covered %0d loads, %0d dropped on full table, %0d probes, %0d clears",
               n_loads, n_full, n_probes, n_clears);
      $display("%0d results checked: %0d match pairs, %0d no-match, %0d mismatches",
               results_seen, n_pairs, n_nomatch, err_count);
      if (err_count == 0) begin
         $display("[nested_loop_equi_join_top] OK");
      end else begin
         $display("[nested_loop_equi_join_top] ERROR");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/nlej_pkg.sv
hw/rtl/nlej_intf.sv
hw/rtl/nlej_ctrl.sv
hw/rtl/nlej_datapath.sv
hw/rtl/nested_loop_equi_join_top.sv
hw/rtl/nlej_checker.sv
dv/tb.sv
